// ----- rtl/core/bvp_pkg.sv -----
// Shared types, constants and saturation helpers for the Boris velocity push unit.
// No dependencies.
package bvp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_res_t;

  // front to back queue entry
  typedef struct packed {
    logic [2:0][31:0] um;
    logic [2:0][31:0] h;
    logic [2:0][31:0] b;
    logic             sat;
  } fq_ent_t;

  // carried alongside the t divider
  typedef struct packed {
    logic [2:0][31:0] um;
    logic [2:0][31:0] h;
    logic             sat;
  } trot_t;

  // carried alongside the s divider
  typedef struct packed {
    logic [2:0][31:0] um;
    logic [2:0][31:0] h;
    logic [2:0][31:0] u0;
    logic             sat;
  } srot_t;

  function automatic logic [65:0] sx32(input logic [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic [65:0] sx64(input logic [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  // clip a 66-bit two's complement value to 32 bits
  function automatic sat_res_t sat32(input logic [65:0] v);
    sat_res_t r;
    if (&v[65:31] || ~|v[65:31]) begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end else begin
      r.sat = 1'b1;
      r.val = v[65] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/bvp_fifo.sv -----
// Short queue decoupling the front end from the back pipeline.
// Depends on nothing but its parameters.
module bvp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/bvp_sqrt.sv -----
// Pipelined floor square root, 64-bit radicand, one result bit per stage.
// Uses only its parameters; side data travels along with each item.
module bvp_sqrt #(
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   rad_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);
  localparam int unsigned STEPS = 32;

  logic          v_q    [STEPS];
  logic [63:0]   x_q    [STEPS];
  logic [33:0]   rem_q  [STEPS];
  logic [31:0]   root_q [STEPS];
  logic [SW-1:0] side_q [STEPS];

  logic          v_in    [STEPS];
  logic [63:0]   x_in    [STEPS];
  logic [33:0]   rem_in  [STEPS];
  logic [31:0]   root_in [STEPS];
  logic [SW-1:0] side_in [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [35:0] r2, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in[k]    = valid_i;
      assign x_in[k]    = rad_i;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign v_in[k]    = v_q[k-1];
      assign x_in[k]    = x_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    assign r2    = {rem_in[k], x_in[k][63:62]};
    assign trial = {2'b00, root_in[k], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {x_in[k][61:0], 2'b00};
        rem_q[k]  <= ge ? 34'(r2 - trial) : r2[33:0];
        root_q[k] <= {root_in[k][30:0], ge};
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

// ----- rtl/core/bvp_div.sv -----
// Three-lane pipelined signed divider with a shared positive divisor,
// one quotient bit per stage, truncating toward zero and clipping to 32 bits.
// Depends on bvp_pkg.
module bvp_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2:0][63:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [2:0][31:0] quo_o,
  output logic             sat_o,
  output logic [SW-1:0]    side_o
);
  import bvp_pkg::*;

  localparam int unsigned STEPS = 32;

  // setup stage
  logic          p_v_q;
  logic [2:0]    p_neg_q, p_ovf_q;
  logic [DW-1:0] p_rem_q [3];
  logic [31:0]   p_lo_q  [3];
  logic [DW-1:0] p_den_q;
  logic [SW-1:0] p_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en_i) begin
      p_v_q <= valid_i;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_setup
    logic [63:0]   mag;
    logic [DW-1:0] hi;
    logic          ovf;
    assign mag = num_i[l][63] ? 64'(-num_i[l]) : num_i[l];
    assign hi  = DW'(mag[62:32]);
    assign ovf = (hi >= den_i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_neg_q[l] <= num_i[l][63];
        p_ovf_q[l] <= ovf;
        p_rem_q[l] <= ovf ? '0 : hi;
        p_lo_q[l]  <= mag[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_den_q  <= den_i;
      p_side_q <= side_i;
    end
  end

  // restoring steps
  logic          st_v_q    [STEPS];
  logic [2:0]    st_neg_q  [STEPS];
  logic [2:0]    st_ovf_q  [STEPS];
  logic [DW-1:0] st_den_q  [STEPS];
  logic [SW-1:0] st_side_q [STEPS];
  logic [DW-1:0] st_rem_q  [STEPS][3];
  logic [31:0]   st_lo_q   [STEPS][3];
  logic [31:0]   st_quo_q  [STEPS][3];

  logic          in_v    [STEPS];
  logic [2:0]    in_neg  [STEPS];
  logic [2:0]    in_ovf  [STEPS];
  logic [DW-1:0] in_den  [STEPS];
  logic [SW-1:0] in_side [STEPS];
  logic [DW-1:0] in_rem  [STEPS][3];
  logic [31:0]   in_lo   [STEPS][3];
  logic [31:0]   in_quo  [STEPS][3];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign in_v[k]    = p_v_q;
      assign in_neg[k]  = p_neg_q;
      assign in_ovf[k]  = p_ovf_q;
      assign in_den[k]  = p_den_q;
      assign in_side[k] = p_side_q;
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign in_rem[k][l] = p_rem_q[l];
        assign in_lo[k][l]  = p_lo_q[l];
        assign in_quo[k][l] = '0;
      end
    end else begin : g_next
      assign in_v[k]    = st_v_q[k-1];
      assign in_neg[k]  = st_neg_q[k-1];
      assign in_ovf[k]  = st_ovf_q[k-1];
      assign in_den[k]  = st_den_q[k-1];
      assign in_side[k] = st_side_q[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign in_rem[k][l] = st_rem_q[k-1][l];
        assign in_lo[k][l]  = st_lo_q[k-1][l];
        assign in_quo[k][l] = st_quo_q[k-1][l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[k] <= 1'b0;
      end else if (en_i) begin
        st_v_q[k] <= in_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_neg_q[k]  <= in_neg[k];
        st_ovf_q[k]  <= in_ovf[k];
        st_den_q[k]  <= in_den[k];
        st_side_q[k] <= in_side[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW:0] r2, dx;
      logic        ge;
      assign r2 = {in_rem[k][l], in_lo[k][l][31]};
      assign dx = {1'b0, in_den[k]};
      assign ge = (r2 >= dx);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_rem_q[k][l] <= ge ? DW'(r2 - dx) : r2[DW-1:0];
          st_lo_q[k][l]  <= {in_lo[k][l][30:0], 1'b0};
          st_quo_q[k][l] <= {in_quo[k][l][30:0], ge};
        end
      end
    end
  end

  // sign and clip
  logic             o_v_q;
  logic [2:0][31:0] o_quo_q;
  logic             o_sat_q;
  logic [SW-1:0]    o_side_q;
  logic [2:0][31:0] quo_d;
  logic             sat_d;

  always_comb begin
    logic [31:0] q;
    logic        s;
    sat_d = 1'b0;
    quo_d = '0;
    for (int l = 0; l < 3; l++) begin
      q = st_quo_q[STEPS-1][l];
      if (st_neg_q[STEPS-1][l]) begin
        s        = st_ovf_q[STEPS-1][l] || (q > WORD_MIN);
        quo_d[l] = s ? WORD_MIN : 32'(-q);
      end else begin
        s        = st_ovf_q[STEPS-1][l] || q[31];
        quo_d[l] = s ? WORD_MAX : q;
      end
      sat_d = sat_d | s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en_i) begin
      o_v_q <= st_v_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_quo_q  <= quo_d;
      o_sat_q  <= sat_d;
      o_side_q <= st_side_q[STEPS-1];
    end
  end

  assign valid_o = o_v_q;
  assign quo_o   = o_quo_q;
  assign sat_o   = o_sat_q;
  assign side_o  = o_side_q;

endmodule

// ----- rtl/core/bvp_front.sv -----
// Front end: takes particle transfers, applies the first half electric kick.
// Depends on bvp_pkg; feeds the queue in bvp_fifo.
module bvp_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       kick_i,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [287:0]      s_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output bvp_pkg::fq_ent_t  q_data_o
);
  import bvp_pkg::*;

  logic              fen;
  logic              f1_v_q, f2_v_q;
  logic [31:0]       f1_u_q [3];
  logic [31:0]       f1_b_q [3];
  logic signed [63:0] f1_p_q [3];
  fq_ent_t           f2_ent_q, f2_ent_d;

  assign fen       = !f2_v_q || !q_full_i;
  assign s_ready_o = fen;
  assign q_push_o  = f2_v_q && !q_full_i;
  assign q_data_o  = f2_ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (fen) begin
      f1_v_q <= s_valid_i;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      for (int l = 0; l < 3; l++) begin
        f1_u_q[l] <= s_data_i[32*l +: 32];
        f1_b_q[l] <= s_data_i[192 + 32*l +: 32];
        f1_p_q[l] <= $signed(kick_i) * $signed(s_data_i[96 + 32*l +: 32]);
      end
      f2_ent_q <= f2_ent_d;
    end
  end

  always_comb begin
    sat_res_t h_r, um_r;
    f2_ent_d     = '0;
    f2_ent_d.sat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      h_r  = sat32(sx64(64'(f1_p_q[l] >>> FRAC_BITS)));
      um_r = sat32(sx32(f1_u_q[l]) + sx32(h_r.val));
      f2_ent_d.h[l]  = h_r.val;
      f2_ent_d.um[l] = um_r.val;
      f2_ent_d.b[l]  = f1_b_q[l];
      f2_ent_d.sat   = f2_ent_d.sat | h_r.sat | um_r.sat;
    end
  end

endmodule

// ----- rtl/core/bvp_back.sv -----
// Back end: gamma, t and s vectors, both rotations and the second half kick.
// Depends on bvp_pkg, bvp_sqrt and bvp_div; whole pipeline stalls on the output register.
module bvp_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      kick_i,
  input  logic             q_valid_i,
  input  bvp_pkg::fq_ent_t q_data_i,
  output logic             q_pop_o,
  input  logic             m_ready_i,
  output logic             m_valid_o,
  output logic [95:0]      m_data_o,
  output logic             m_sat_o
);
  import bvp_pkg::*;

  localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ACC0  = 64'(1) << (2 * FRAC_BITS);

  logic en;
  logic m_valid_q;
  logic [95:0] m_data_q;
  logic m_sat_q;

  assign en       = !m_valid_q || m_ready_i;
  assign q_pop_o  = en;
  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_sat_o   = m_sat_q;

  // squares and sum
  logic        a_v_q, b_v_q;
  fq_ent_t     a_ent_q, b_ent_q;
  logic [63:0] a_sq_q [3];
  logic [63:0] b_acc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ent_q <= q_data_i;
      for (int l = 0; l < 3; l++) begin
        a_sq_q[l] <= $signed(q_data_i.um[l]) * $signed(q_data_i.um[l]);
      end
      b_ent_q <= a_ent_q;
      b_acc_q <= ACC0 + a_sq_q[0] + a_sq_q[1] + a_sq_q[2];
    end
  end

  // gamma
  logic        sq_v;
  logic [31:0] sq_root;
  fq_ent_t     sq_ent;

  bvp_sqrt #(.SW($bits(fq_ent_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .rad_i   (b_acc_q),
    .side_i  (b_ent_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_ent)
  );

  logic             c_v_q;
  logic [31:0]      c_gamma_q;
  logic [2:0][63:0] c_kb_q;
  trot_t            c_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_gamma_q <= sq_root[31] ? WORD_MAX : sq_root;
      for (int l = 0; l < 3; l++) begin
        c_kb_q[l] <= $signed(kick_i) * $signed(sq_ent.b[l]);
      end
      c_side_q <= trot_t'{um: sq_ent.um, h: sq_ent.h, sat: sq_ent.sat | sq_root[31]};
    end
  end

  // t = k*B / gamma
  logic             dt_v, dt_sat;
  logic [2:0][31:0] dt_quo;
  trot_t            dt_side;

  bvp_div #(.DW(32), .SW($bits(trot_t))) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .num_i   (c_kb_q),
    .den_i   (c_gamma_q),
    .side_i  (c_side_q),
    .valid_o (dt_v),
    .quo_o   (dt_quo),
    .sat_o   (dt_sat),
    .side_o  (dt_side)
  );

  // first rotation products and |t|^2 terms
  logic               d_v_q;
  logic signed [63:0] d_pp_q  [3];
  logic signed [63:0] d_pm_q  [3];
  logic [63:0]        d_tsq_q [3];
  logic [2:0][31:0]   d_t_q;
  trot_t              d_side_q;

  for (genvar l = 0; l < 3; l++) begin : g_rot1
    localparam int unsigned IA = (l + 1) % 3;
    localparam int unsigned IB = (l + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_pp_q[l]  <= $signed(dt_side.um[IA]) * $signed(dt_quo[IB]);
        d_pm_q[l]  <= $signed(dt_side.um[IB]) * $signed(dt_quo[IA]);
        d_tsq_q[l] <= $signed(dt_quo[l]) * $signed(dt_quo[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_t_q    <= dt_quo;
      d_side_q <= trot_t'{um: dt_side.um, h: dt_side.h, sat: dt_side.sat | dt_sat};
    end
  end

  // u0, denominator and numerators for s
  logic             e_v_q;
  logic [2:0][63:0] e_snum_q;
  logic [63:0]      e_den_q;
  srot_t            e_side_q, e_side_d;

  always_comb begin
    sat_res_t r;
    e_side_d     = '0;
    e_side_d.um  = d_side_q.um;
    e_side_d.h   = d_side_q.h;
    e_side_d.sat = d_side_q.sat;
    for (int l = 0; l < 3; l++) begin
      r = sat32(sx32(d_side_q.um[l]) + sx64(64'(d_pp_q[l] >>> FRAC_BITS))
                - sx64(64'(d_pm_q[l] >>> FRAC_BITS)));
      e_side_d.u0[l] = r.val;
      e_side_d.sat   = e_side_d.sat | r.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_side_q <= e_side_d;
      e_den_q  <= ONE_Q + (d_tsq_q[0] >> FRAC_BITS) + (d_tsq_q[1] >> FRAC_BITS)
                  + (d_tsq_q[2] >> FRAC_BITS);
      for (int l = 0; l < 3; l++) begin
        e_snum_q[l] <= {{32{d_t_q[l][31]}}, d_t_q[l]} << (FRAC_BITS + 1);
      end
    end
  end

  // s = 2t / (1 + |t|^2)
  logic             ds_v, ds_sat;
  logic [2:0][31:0] ds_quo;
  srot_t            ds_side;

  bvp_div #(.DW(64), .SW($bits(srot_t))) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_v_q),
    .num_i   (e_snum_q),
    .den_i   (e_den_q),
    .side_i  (e_side_q),
    .valid_o (ds_v),
    .quo_o   (ds_quo),
    .sat_o   (ds_sat),
    .side_o  (ds_side)
  );

  // second rotation
  logic               f_v_q;
  logic signed [63:0] f_pp_q [3];
  logic signed [63:0] f_pm_q [3];
  srot_t              f_side_q;

  for (genvar l = 0; l < 3; l++) begin : g_rot2
    localparam int unsigned IA = (l + 1) % 3;
    localparam int unsigned IB = (l + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en) begin
        f_pp_q[l] <= $signed(ds_side.u0[IA]) * $signed(ds_quo[IB]);
        f_pm_q[l] <= $signed(ds_side.u0[IB]) * $signed(ds_quo[IA]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_side_q <= srot_t'{um: ds_side.um, h: ds_side.h, u0: ds_side.u0,
                          sat: ds_side.sat | ds_sat};
    end
  end

  logic             g_v_q;
  logic [2:0][31:0] g_up_q, g_up_d, g_h_q;
  logic             g_sat_q, g_sat_d;

  always_comb begin
    sat_res_t r;
    g_up_d  = '0;
    g_sat_d = f_side_q.sat;
    for (int l = 0; l < 3; l++) begin
      r = sat32(sx32(f_side_q.um[l]) + sx64(64'(f_pp_q[l] >>> FRAC_BITS))
                - sx64(64'(f_pm_q[l] >>> FRAC_BITS)));
      g_up_d[l] = r.val;
      g_sat_d   = g_sat_d | r.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_up_q  <= g_up_d;
      g_h_q   <= f_side_q.h;
      g_sat_q <= g_sat_d;
    end
  end

  // second half kick into the output register
  logic [95:0] m_data_d;
  logic        m_sat_d;

  always_comb begin
    sat_res_t r;
    m_data_d = '0;
    m_sat_d  = g_sat_q;
    for (int l = 0; l < 3; l++) begin
      r = sat32(sx32(g_up_q[l]) + sx32(g_h_q[l]));
      m_data_d[32*l +: 32] = r.val;
      m_sat_d = m_sat_d | r.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= m_data_d;
      m_sat_q  <= m_sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      d_v_q     <= 1'b0;
      e_v_q     <= 1'b0;
      f_v_q     <= 1'b0;
      g_v_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      a_v_q     <= q_valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= sq_v;
      d_v_q     <= dt_v;
      e_v_q     <= d_v_q;
      f_v_q     <= ds_v;
      g_v_q     <= f_v_q;
      m_valid_q <= g_v_q;
    end
  end

endmodule

// ----- rtl/core/boris_velocity_push_unit.sv -----
// Relativistic Boris momentum push, one particle per cycle while the output is not stalled.
// Throughput: one transfer per cycle unless the output stalls; the square root and both dividers are
// pipelined one result bit per stage, with 32 such stages each.
// Reset: clears all valid flags, the queue and kick_factor (to zero).
// Top level; depends on bvp_pkg, bvp_front, bvp_fifo, bvp_back.
module boris_velocity_push_unit #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mom_x_in, mom_y_in, mom_z_in, efield_x/y/z, bfield_x/y/z, 32 bits each
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mom_x_out, mom_y_out, mom_z_out, 32 bits each
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bvp_pkg::*;

  logic [31:0] kick_q, kick_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? '0 : kick_q;

  always_comb begin
    kick_d = kick_q;
    if (cfg_wr && !paddr[2]) begin
      kick_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_q <= '0;
    end else begin
      kick_q <= kick_d;
    end
  end

  logic    q_push, q_full, q_pop, q_valid;
  fq_ent_t q_wdata, q_rdata;

  bvp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kick_i    (kick_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  bvp_fifo #(.W($bits(fq_ent_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  bvp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kick_i    (kick_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_sat_o   (m_axis_tuser)
  );

  a_front_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_full)
    else $error("front stalled with room in the queue");

  a_back_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !q_pop)
    else $error("queue popped while result stalled");

  a_kick_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) |=> (kick_q == $past(pwdata)))
    else $error("kick_factor write lost");

endmodule

// ----- tb/tb_boris_velocity_push_unit.sv -----
// Self-checking testbench for boris_velocity_push_unit: streams particles through the
// relativistic Boris push and compares every result with an in-bench fixed-point predictor.
// Depends on the RTL top level only; the kick factor is set and read back through APB.
`timescale 1ns / 100ps

module tb_boris_velocity_push_unit;

  localparam int FRAC = 16;
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;
  localparam logic [2:0] ADDR_KICK = 3'd0;
  localparam logic [2:0] ADDR_NONE = 3'd4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic [8:0][31:0] particle_t;   // ux uy uz ex ey ez bx by bz, low to high
  typedef struct packed {
    logic [2:0][31:0] mom;
    logic             sat;
  } push_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  boris_velocity_push_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  particle_t pending_q[$];
  push_res_t momentum_q[$];
  longint kick_val = 0;
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_sat = 0;
  int cycles = 0;

  function automatic longint clip32(input longint v, inout bit f);
    if (v > W_MAX) begin
      f = 1'b1;
      return W_MAX;
    end
    if (v < W_MIN) begin
      f = 1'b1;
      return W_MIN;
    end
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      if (trial * trial <= x) res = trial;
    end
    return longint'(res);
  endfunction

  function automatic push_res_t boris_push(input longint k, input particle_t p);
    longint u[3], e[3], b[3], h[3], um[3], t[3], u0[3], s[3], up[3];
    logic [63:0] acc;
    longint gam, den;
    bit f;
    int j, m;
    push_res_t r;
    f = 1'b0;
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'($signed(p[i]));
      e[i] = longint'($signed(p[3 + i]));
      b[i] = longint'($signed(p[6 + i]));
      h[i] = clip32(qmul(k, e[i]), f);
      um[i] = clip32(u[i] + h[i], f);
    end
    acc = 64'd1 << (2 * FRAC);
    for (int i = 0; i < 3; i++) acc = acc + 64'(um[i] * um[i]);
    gam = clip32(floor_sqrt(acc), f);
    for (int i = 0; i < 3; i++) t[i] = clip32((k * b[i]) / gam, f);
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      u0[i] = clip32(um[i] + qmul(um[j], t[m]) - qmul(um[m], t[j]), f);
    end
    den = longint'(1) << FRAC;
    for (int i = 0; i < 3; i++) den = den + ((t[i] * t[i]) >>> FRAC);
    for (int i = 0; i < 3; i++) s[i] = clip32((t[i] * 2 * (longint'(1) << FRAC)) / den, f);
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      up[i] = clip32(um[i] + qmul(u0[j], s[m]) - qmul(u0[m], s[j]), f);
    end
    for (int i = 0; i < 3; i++) r.mom[i] = 32'(clip32(up[i] + h[i], f));
    r.sat = f;
    return r;
  endfunction

  // sender: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    logic load;
    load = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      momentum_q.push_back(boris_push(kick_val, particle_t'(s_axis_tdata)));
      n_sent++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        load = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (load) s_axis_tdata <= pending_q.pop_front();
      s_axis_tvalid <= load;
    end
  end

  // receiver: randomly switches among four stall patterns, plus one long hold-off
  int ready_mode = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (cycles % 64 == 0) ready_mode = $urandom_range(0, 3);
    if (!hold_done && n_recv >= 120) begin
      hold_done = 1'b1;
      hold_cnt = 500;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    push_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_recv++;
      if (m_axis_tuser) n_sat++;
      if (momentum_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer tdata=%h tuser=%b", $time, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        want = momentum_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_axis_tdata[32*i +: 32] !== want.mom[i]) begin
            errors++;
            $display("%0t: mom[%0d] expected %h actual %h", $time, i, want.mom[i],
                     m_axis_tdata[32*i +: 32]);
          end
        end
        if (m_axis_tuser !== want.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, want.sat, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               momentum_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_KICK) kick_val = longint'($signed(data));
  endtask

  task automatic check_kick;
    @(posedge clk_i);
    psel <= 1'b1;
    paddr <= ADDR_KICK;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(kick_val)) begin
      errors++;
      $display("%0t: kick_factor readback expected %h actual %h", $time, 32'(kick_val),
               prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || s_axis_tvalid || momentum_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh2000);
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  task automatic add_random(input int n);
    particle_t p;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) p[i] = rand_field();
      pending_q.push_back(p);
    end
  endtask

  task automatic add_uniform(input logic [31:0] mom, input logic [31:0] ef,
                             input logic [31:0] bf);
    particle_t p;
    for (int i = 0; i < 3; i++) begin
      p[i] = mom;
      p[3 + i] = ef;
      p[6 + i] = bf;
    end
    pending_q.push_back(p);
  endtask

  initial begin
    particle_t p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_kick;

    // reset value of the kick factor: fields have no effect
    add_uniform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_uniform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_random(20);
    drain();

    apb_write(ADDR_KICK, 32'h0001_0000);
    check_kick;
    add_uniform(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_uniform(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    add_uniform(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    add_uniform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_uniform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_uniform(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_uniform(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_uniform(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff);
    add_uniform(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
    add_uniform(32'h0000_0001, 32'h0000_0000, 32'h0001_0000);
    p = '0;
    p[0] = 32'h0001_0000;
    p[8] = 32'h0003_0000;
    pending_q.push_back(p);   // pure rotation about z
    p = '0;
    p[4] = 32'h0000_8000;
    pending_q.push_back(p);   // pure electric kick
    p = '0;
    p[1] = 32'hfffe_0000;
    p[6] = 32'hffff_8000;
    p[5] = 32'h0000_4000;
    pending_q.push_back(p);
    for (int i = 0; i < 9; i++) p[i] = 32'h5555_5555 << (i % 2);
    pending_q.push_back(p);
    for (int i = 0; i < 9; i++) p[i] = 32'haaaa_aaaa >> (i % 2);
    pending_q.push_back(p);
    add_random(220);
    drain();

    // unmapped address leaves the kick factor alone; the readback follows the next kick write
    apb_write(ADDR_NONE, 32'hdead_beef);
    apb_write(ADDR_KICK, 32'h0000_0800);
    check_kick;
    add_random(150);
    drain();

    apb_write(ADDR_KICK, 32'h7fff_ffff);
    check_kick;
    add_random(50);
    drain();

    apb_write(ADDR_KICK, 32'h8000_0000);
    check_kick;
    add_random(50);
    drain();

    apb_write(ADDR_KICK, 32'hffff_c000);
    check_kick;
    add_random(50);
    drain();

    apb_write(ADDR_KICK, $urandom());
    check_kick;
    add_random(50);
    drain();

    $display("%0d particles pushed, %0d results checked, %0d saturated, 7 kick factors",
             n_sent, n_recv, n_sat);
    $display("receiver long hold-off %s; %0d errors", hold_done ? "done" : "missed", errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
